/* hw/rtl/ccpe_pkg.sv */
`timescale 1ns / 1ps
package ccpe_pkg;

   localparam int T_W   = 32;  // carried parameter, sign extended
   localparam int XY_W  = 34;  // cos and sin datapath, Q.30
   localparam int ANG_W = 36;  // residual angle, Q.30
   localparam int TAB_LEN = 30;
   localparam int VEC_W = 63;  // packed vector registers

   localparam logic [2:0] REG_KIND   = 3'd0;
   localparam logic [2:0] REG_ORIGIN = 3'd1;
   localparam logic [2:0] REG_AXIS   = 3'd2;
   localparam logic [2:0] REG_NORMAL = 3'd3;
   localparam logic [2:0] REG_RADIUS = 3'd4;
   localparam logic [2:0] REG_SEMI_A = 3'd5;
   localparam logic [2:0] REG_SEMI_B = 3'd6;

   localparam logic [1:0] KIND_LINE    = 2'd0;
   localparam logic [1:0] KIND_CIRCLE  = 2'd1;
   localparam logic [1:0] KIND_ELLIPSE = 2'd2;

   localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
   localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;

   localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
      36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
      36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
      36'sd4194283, 36'sd2097149, 36'sd1048576, 36'sd524288, 36'sd262144,
      36'sd131072, 36'sd65536, 36'sd32768, 36'sd16384, 36'sd8192,
      36'sd4096, 36'sd2048, 36'sd1024, 36'sd512, 36'sd256, 36'sd128,
      36'sd64, 36'sd32, 36'sd16, 36'sd8, 36'sd4, 36'sd2
   };

   typedef struct packed {
      logic                    valid;
      logic                    flip;
      logic signed [T_W-1:0]   t;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] a;
   } cordic_type;

endpackage

/* hw/rtl/conic_curve_point_eval_3d.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  req_tdata: t_param
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: x, y, z; rsp_tuser: saturated
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One word per cycle while rsp is not stalled; the pipeline has one reduction stage,
// one stage per CORDIC iteration, two multiply stages and one sum and clip stage.
// The binormal follows the configuration through its cross-term and difference registers.
// Synchronous reset clears the valid bits and the configuration registers.
// A stall on rsp holds the whole pipeline; nothing is dropped or repeated.
module conic_curve_point_eval_3d #(
   parameter int COORD_WIDTH  = 21,
   parameter int PARAM_WIDTH  = 24,
   parameter int CORDIC_STEPS = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((PARAM_WIDTH+7)/8)*8-1:0]      req_tdata,  // t_param
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    rsp_tdata,  // point_x, point_y, point_z
   output logic                                  rsp_tuser,  // saturated
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [2:0]                            csr_index,
   input  logic [ccpe_pkg::VEC_W-1:0]            csr_data
);

   localparam int CW    = COORD_WIDTH;
   localparam int PW    = PARAM_WIDTH;
   localparam int PF    = PW - 4;
   localparam int NS    = (CORDIC_STEPS < ccpe_pkg::TAB_LEN) ? CORDIC_STEPS
                                                              : ccpe_pkg::TAB_LEN;
   localparam int OUT_W = ((3*CW+7)/8)*8;
   localparam int T_W   = ccpe_pkg::T_W;
   localparam int XY_W  = ccpe_pkg::XY_W;
   localparam int ANG_W = ccpe_pkg::ANG_W;
   localparam int VEC_W = ccpe_pkg::VEC_W;
   localparam int AMP_W = CW + 3;
   localparam int AP_W  = CW + XY_W;
   localparam int LP_W  = T_W + CW;
   localparam int TP_W  = CW + AMP_W;
   localparam int SUM_W = T_W + CW + 4;
   localparam logic signed [SUM_W-1:0] HI = SUM_W'((64'sd1 <<< (CW - 1)) - 1);
   localparam logic signed [SUM_W-1:0] LO = -SUM_W'(64'sd1 <<< (CW - 1));

   // Configuration registers.
   logic [1:0]       kind_ff;
   logic [VEC_W-1:0] origin_ff, axis_ff, normal_ff;
   logic [CW-2:0]    radius_ff, semi_a_ff, semi_b_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= ccpe_pkg::KIND_LINE;
         origin_ff <= '0;
         axis_ff   <= '0;
         normal_ff <= '0;
         radius_ff <= '0;
         semi_a_ff <= '0;
         semi_b_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ccpe_pkg::REG_KIND:   kind_ff   <= csr_data[1:0];
            ccpe_pkg::REG_ORIGIN: origin_ff <= csr_data;
            ccpe_pkg::REG_AXIS:   axis_ff   <= csr_data;
            ccpe_pkg::REG_NORMAL: normal_ff <= csr_data;
            ccpe_pkg::REG_RADIUS: radius_ff <= csr_data[CW-2:0];
            ccpe_pkg::REG_SEMI_A: semi_a_ff <= csr_data[CW-2:0];
            ccpe_pkg::REG_SEMI_B: semi_b_ff <= csr_data[CW-2:0];
            default: ;
         endcase
      end
   end

   logic [3*CW+VEC_W-1:0] org_ext, ax_ext;
   logic signed [CW-1:0]  org_c [3];
   logic signed [CW-1:0]  ax_c [3];
   logic signed [CW-1:0]  bn_c [3];

   assign org_ext = {{(3*CW){1'b0}}, origin_ff};
   assign ax_ext  = {{(3*CW){1'b0}}, axis_ff};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         org_c[k] = signed'(org_ext[k*CW +: CW]);
         ax_c[k]  = signed'(ax_ext[k*CW +: CW]);
      end
   end

   ccpe_binormal #(.COORD_WIDTH(CW)) u_binormal (
      .clock      (clock),
      .axis_xyz   (axis_ff),
      .normal_xyz (normal_ff),
      .binormal   (bn_c)
   );

   // The whole pipeline moves together unless the result word is held.
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Angle reduction into [-pi/2, pi/2]; |t| < 8 needs one 2pi step at most.
   ccpe_pkg::cordic_type cord [NS+1];
   ccpe_pkg::cordic_type red_ff, red_in;

   always_comb begin
      logic signed [T_W-1:0]   t32;
      logic signed [ANG_W-1:0] a0, a1;
      t32 = T_W'(signed'(req_tdata[PW-1:0]));
      a0  = ANG_W'(t32) <<< (30 - PF);
      if (a0 > ccpe_pkg::ANG_PI) begin
         a1 = a0 - ccpe_pkg::ANG_TWO_PI;
      end else if (a0 < -ccpe_pkg::ANG_PI) begin
         a1 = a0 + ccpe_pkg::ANG_TWO_PI;
      end else begin
         a1 = a0;
      end
      red_in.valid = req_tvalid;
      red_in.t     = t32;
      red_in.x     = ccpe_pkg::CORDIC_GAIN;
      red_in.y     = '0;
      if (a1 > ccpe_pkg::ANG_HALF_PI) begin
         red_in.a    = a1 - ccpe_pkg::ANG_PI;
         red_in.flip = 1'b1;
      end else if (a1 < -ccpe_pkg::ANG_HALF_PI) begin
         red_in.a    = a1 + ccpe_pkg::ANG_PI;
         red_in.flip = 1'b1;
      end else begin
         red_in.a    = a1;
         red_in.flip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff.valid <= 1'b0;
      end else if (adv) begin
         red_ff.valid <= red_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff.flip <= red_in.flip;
         red_ff.t    <= red_in.t;
         red_ff.x    <= red_in.x;
         red_ff.y    <= red_in.y;
         red_ff.a    <= red_in.a;
      end
   end

   assign cord[0] = red_ff;

   for (genvar i = 0; i < NS; i++) begin : g_cordic
      ccpe_cordic_stage #(.STEP(i)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_in  (cord[i]),
         .stage_out (cord[i+1])
      );
   end

   // First multiply stage: amplitudes and the line products.
   logic                    e1_valid_ff;
   logic signed [AMP_W-1:0] amp_c_ff, amp_s_ff, amp_c_in, amp_s_in;
   logic signed [LP_W-1:0]  lp_ff [3];
   logic signed [LP_W-1:0]  lp_in [3];

   always_comb begin
      logic signed [XY_W-1:0] cx, sy;
      logic [CW-2:0]          ra, rb;
      logic signed [AP_W-1:0] pc, ps;
      cx = cord[NS].flip ? -cord[NS].x : cord[NS].x;
      sy = cord[NS].flip ? -cord[NS].y : cord[NS].y;
      ra = (kind_ff == ccpe_pkg::KIND_CIRCLE) ? radius_ff : semi_a_ff;
      rb = (kind_ff == ccpe_pkg::KIND_CIRCLE) ? radius_ff : semi_b_ff;
      pc = AP_W'(signed'({1'b0, ra})) * AP_W'(cx);
      ps = AP_W'(signed'({1'b0, rb})) * AP_W'(sy);
      amp_c_in = AMP_W'((pc + (AP_W'(1) <<< 29)) >>> 30);
      amp_s_in = AMP_W'((ps + (AP_W'(1) <<< 29)) >>> 30);
      for (int k = 0; k < 3; k++) begin
         lp_in[k] = LP_W'(cord[NS].t) * LP_W'(ax_c[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff <= cord[NS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         amp_c_ff <= amp_c_in;
         amp_s_ff <= amp_s_in;
         lp_ff    <= lp_in;
      end
   end

   // Second multiply stage: vector terms, each rounded to Q.10.
   logic                    e2_valid_ff;
   logic signed [SUM_W-1:0] tc_ff [3];
   logic signed [SUM_W-1:0] ts_ff [3];
   logic signed [SUM_W-1:0] tl_ff [3];
   logic signed [SUM_W-1:0] tc_in [3];
   logic signed [SUM_W-1:0] ts_in [3];
   logic signed [SUM_W-1:0] tl_in [3];

   always_comb begin
      logic signed [TP_W-1:0] pc, ps;
      for (int k = 0; k < 3; k++) begin
         pc = TP_W'(ax_c[k]) * TP_W'(amp_c_ff);
         ps = TP_W'(bn_c[k]) * TP_W'(amp_s_ff);
         tc_in[k] = SUM_W'((pc + TP_W'(512)) >>> 10);
         ts_in[k] = SUM_W'((ps + TP_W'(512)) >>> 10);
         tl_in[k] = SUM_W'((lp_ff[k] + (LP_W'(1) <<< (PF - 1))) >>> PF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (adv) begin
         e2_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tc_ff <= tc_in;
         ts_ff <= ts_in;
         tl_ff <= tl_in;
      end
   end

   // Sum, clip and the output word.
   logic                 rsp_valid_ff, sat_ff, sat_in;
   logic signed [CW-1:0] pt_ff [3];
   logic signed [CW-1:0] pt_in [3];

   always_comb begin
      logic signed [SUM_W-1:0] s;
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         case (kind_ff) inside
            ccpe_pkg::KIND_LINE: s = SUM_W'(org_c[k]) + tl_ff[k];
            ccpe_pkg::KIND_CIRCLE, ccpe_pkg::KIND_ELLIPSE:
               s = SUM_W'(org_c[k]) + tc_ff[k] + ts_ff[k];
            default: s = SUM_W'(org_c[k]);
         endcase
         if (s > HI) begin
            pt_in[k] = HI[CW-1:0];
            sat_in   = 1'b1;
         end else if (s < LO) begin
            pt_in[k] = LO[CW-1:0];
            sat_in   = 1'b1;
         end else begin
            pt_in[k] = s[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= e2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff  <= pt_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({pt_ff[2], pt_ff[1], pt_ff[0]});
   assign rsp_tuser  = sat_ff;

`ifndef SYNTHESIS
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         pt_ff[0] == HI[CW-1:0] || pt_ff[0] == LO[CW-1:0] ||
         pt_ff[1] == HI[CW-1:0] || pt_ff[1] == LO[CW-1:0] ||
         pt_ff[2] == HI[CW-1:0] || pt_ff[2] == LO[CW-1:0])
      else $error("saturated flag without a clipped coordinate");
   a_cordic_to_e1: assert property (@(posedge clock) disable iff (reset)
      adv && cord[NS].valid |=> e1_valid_ff)
      else $error("word lost leaving the CORDIC");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(e1_valid_ff) && $stable(e2_valid_ff))
      else $error("pipeline moved during a stall");
`endif

endmodule

/* hw/rtl/ccpe_cordic_stage.sv */
`timescale 1ns / 1ps
module ccpe_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  ccpe_pkg::cordic_type  stage_in,
   output ccpe_pkg::cordic_type  stage_out
);

   ccpe_pkg::cordic_type stage_ff, stage_in_c;

   always_comb begin
      stage_in_c = stage_in;
      if (stage_in.a >= 0) begin
         stage_in_c.x = stage_in.x - (stage_in.y >>> STEP);
         stage_in_c.y = stage_in.y + (stage_in.x >>> STEP);
         stage_in_c.a = stage_in.a - ccpe_pkg::ATAN_TAB[STEP];
      end else begin
         stage_in_c.x = stage_in.x + (stage_in.y >>> STEP);
         stage_in_c.y = stage_in.y - (stage_in.x >>> STEP);
         stage_in_c.a = stage_in.a + ccpe_pkg::ATAN_TAB[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff.valid <= stage_in_c.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff.flip <= stage_in_c.flip;
         stage_ff.t    <= stage_in_c.t;
         stage_ff.x    <= stage_in_c.x;
         stage_ff.y    <= stage_in_c.y;
         stage_ff.a    <= stage_in_c.a;
      end
   end

   assign stage_out = stage_ff;

endmodule

/* hw/rtl/ccpe_binormal.sv */
`timescale 1ns / 1ps
module ccpe_binormal #(
   parameter int COORD_WIDTH = 21
) (
   input  logic                               clock,
   input  logic [ccpe_pkg::VEC_W-1:0]         axis_xyz,
   input  logic [ccpe_pkg::VEC_W-1:0]         normal_xyz,
   output logic signed [COORD_WIDTH-1:0]      binormal [3]
);

   localparam int CW  = COORD_WIDTH;
   localparam int PW2 = 2 * CW;
   localparam int RW  = PW2 - 9;
   localparam int DW  = RW + 1;
   localparam logic signed [DW-1:0] HI = DW'((64'sd1 <<< (CW - 1)) - 1);
   localparam logic signed [DW-1:0] LO = -DW'(64'sd1 <<< (CW - 1));

   logic [3*CW+ccpe_pkg::VEC_W-1:0] ax_ext, nm_ext;
   logic signed [CW-1:0] ax [3];
   logic signed [CW-1:0] nm [3];
   logic signed [RW-1:0] pos_ff [3];
   logic signed [RW-1:0] neg_ff [3];
   logic signed [RW-1:0] pos_in [3];
   logic signed [RW-1:0] neg_in [3];
   logic signed [CW-1:0] bn_ff [3];
   logic signed [CW-1:0] bn_in [3];

   assign ax_ext = {{(3*CW){1'b0}}, axis_xyz};
   assign nm_ext = {{(3*CW){1'b0}}, normal_xyz};

   // Each cross term is rounded to Q.10 on its own, before the difference.
   always_comb begin
      logic signed [PW2-1:0] p1, p2;
      logic signed [DW-1:0]  d;
      for (int k = 0; k < 3; k++) begin
         ax[k] = signed'(ax_ext[k*CW +: CW]);
         nm[k] = signed'(nm_ext[k*CW +: CW]);
      end
      for (int k = 0; k < 3; k++) begin
         p1 = PW2'(nm[(k+1)%3]) * PW2'(ax[(k+2)%3]);
         p2 = PW2'(nm[(k+2)%3]) * PW2'(ax[(k+1)%3]);
         pos_in[k] = RW'((p1 + PW2'(512)) >>> 10);
         neg_in[k] = RW'((p2 + PW2'(512)) >>> 10);
         d = DW'(pos_ff[k]) - DW'(neg_ff[k]);
         if (d > HI) begin
            bn_in[k] = HI[CW-1:0];
         end else if (d < LO) begin
            bn_in[k] = LO[CW-1:0];
         end else begin
            bn_in[k] = d[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      bn_ff  <= bn_in;
   end

   assign binormal = bn_ff;

endmodule

/* tb/conic_curve_point_eval_3d_test.sv */
`timescale 1ns / 1ps
module conic_curve_point_eval_3d_test;

   localparam int CW = 21;
   localparam int PW = 24;
   localparam int STEPS = 20;
   localparam int LATENCY = STEPS + 4;
   localparam int IDLE_LIMIT = 20000;
   // The one kind code with no curve behind it.
   localparam logic [1:0] KIND_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;  // t_param
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;  // point_x, point_y, point_z
   logic rsp_tuser;  // saturated
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [62:0] csr_data = '0;

   conic_curve_point_eval_3d dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct {
      logic [CW-1:0] px, py, pz;
      logic sat;
   } point_type;

   int errors = 0;
   int idle_cycles = 0;
   int results_seen = 0;
   int sat_seen = 0;
   bit hold_off = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %0d: %s got %0h expected %0h", results_seen, what, got, want);
      errors++;
   endtask

   // Predictor state: a shadow copy of the configuration registers.
   logic [1:0] kind_reg = ccpe_pkg::KIND_LINE;
   logic [62:0] origin_reg = '0, axis_reg = '0, normal_reg = '0;
   logic [19:0] radius_reg = '0, semi_a_reg = '0, semi_b_reg = '0;

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint round_sh(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint comp(logic [62:0] packed_v, int k);
      logic signed [CW-1:0] c;
      c = packed_v[k*CW +: CW];
      return longint'(c);
   endfunction

   function automatic longint clip_coord(longint v, ref bit flag);
      longint hi, lo;
      hi = (longint'(1) << (CW - 1)) - 1;
      lo = -(longint'(1) << (CW - 1));
      if (v > hi) begin
         flag = 1;
         return hi;
      end
      if (v < lo) begin
         flag = 1;
         return lo;
      end
      return v;
   endfunction

   function automatic point_type curve_point(logic [PW-1:0] t_raw);
      longint t, org[3], ax[3], nm[3], res[3], bn[3];
      longint a, x, y, nx, c, s, ra, rb, amp_c, amp_s, v;
      bit sat, dummy, flip;
      point_type p;
      t = longint'($signed(t_raw));
      sat = 0;
      dummy = 0;
      flip = 0;
      for (int k = 0; k < 3; k++) begin
         org[k] = comp(origin_reg, k);
         ax[k] = comp(axis_reg, k);
         nm[k] = comp(normal_reg, k);
         res[k] = org[k];
      end
      if (kind_reg == ccpe_pkg::KIND_LINE) begin
         for (int k = 0; k < 3; k++)
            res[k] = clip_coord(org[k] + round_sh(t * ax[k], PW - 4), sat);
      end else if (kind_reg == ccpe_pkg::KIND_CIRCLE ||
                   kind_reg == ccpe_pkg::KIND_ELLIPSE) begin
         a = t <<< (30 - (PW - 4));
         x = ccpe_pkg::CORDIC_GAIN;
         y = 0;
         while (a > ccpe_pkg::ANG_PI) a -= ccpe_pkg::ANG_TWO_PI;
         while (a < -ccpe_pkg::ANG_PI) a += ccpe_pkg::ANG_TWO_PI;
         if (a > ccpe_pkg::ANG_HALF_PI) begin
            a -= ccpe_pkg::ANG_PI;
            flip = 1;
         end else if (a < -ccpe_pkg::ANG_HALF_PI) begin
            a += ccpe_pkg::ANG_PI;
            flip = 1;
         end
         for (int i = 0; i < STEPS && i < 30; i++) begin
            if (a >= 0) begin
               nx = x - floor_sh(y, i);
               y = y + floor_sh(x, i);
               a -= ccpe_pkg::ATAN_TAB[i];
            end else begin
               nx = x + floor_sh(y, i);
               y = y - floor_sh(x, i);
               a += ccpe_pkg::ATAN_TAB[i];
            end
            x = nx;
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
         ra = (kind_reg == ccpe_pkg::KIND_CIRCLE) ? radius_reg : semi_a_reg;
         rb = (kind_reg == ccpe_pkg::KIND_CIRCLE) ? radius_reg : semi_b_reg;
         amp_c = round_sh(ra * c, 30);
         amp_s = round_sh(rb * s, 30);
         for (int k = 0; k < 3; k++) begin
            v = round_sh(nm[(k + 1) % 3] * ax[(k + 2) % 3], 10)
                - round_sh(nm[(k + 2) % 3] * ax[(k + 1) % 3], 10);
            bn[k] = clip_coord(v, dummy);
         end
         for (int k = 0; k < 3; k++) begin
            v = org[k] + round_sh(ax[k] * amp_c, 10) + round_sh(bn[k] * amp_s, 10);
            res[k] = clip_coord(v, sat);
         end
      end
      p.px = res[0][CW-1:0];
      p.py = res[1][CW-1:0];
      p.pz = res[2][CW-1:0];
      p.sat = sat;
      return p;
   endfunction

   class point_scoreboard;
      point_type pending[$];

      function void note_param(logic [PW-1:0] t_raw);
         pending.push_back(curve_point(t_raw));
      endfunction

      task check_point(logic [63:0] data, logic sat);
         point_type e;
         results_seen++;
         if (sat) sat_seen++;
         if (pending.size() == 0) begin
            report("unexpected word", data, 0);
            return;
         end
         e = pending.pop_front();
         if (data[CW-1:0] !== e.px) report("point_x", data[CW-1:0], e.px);
         if (data[2*CW-1:CW] !== e.py) report("point_y", data[2*CW-1:CW], e.py);
         if (data[3*CW-1:2*CW] !== e.pz) report("point_z", data[3*CW-1:2*CW], e.pz);
         if (data[63:3*CW] !== '0) report("pad bit", data[63:3*CW], 0);
         if (sat !== e.sat) report("saturated", sat, e.sat);
      endtask
   endclass

   point_scoreboard board = new();

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
         if (req_tvalid && req_tready) board.note_param(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_point(rsp_tdata, rsp_tuser);
      end
   end

   // Receiver: random stalls, with a long hold-off when asked.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < 300; i++) @(negedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 5) == 0) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(negedge clock);
      end
   end

   // Back-to-back writes keep csr_valid high; the next send lowers it.
   task automatic write_reg(logic [2:0] idx, logic [62:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      case (idx)
         ccpe_pkg::REG_KIND: kind_reg = value[1:0];
         ccpe_pkg::REG_ORIGIN: origin_reg = value;
         ccpe_pkg::REG_AXIS: axis_reg = value;
         ccpe_pkg::REG_NORMAL: normal_reg = value;
         ccpe_pkg::REG_RADIUS: radius_reg = value[19:0];
         ccpe_pkg::REG_SEMI_A: semi_a_reg = value[19:0];
         ccpe_pkg::REG_SEMI_B: semi_b_reg = value[19:0];
         default: ;
      endcase
   endtask

   task automatic send_param(logic [PW-1:0] t_raw, bit no_gap);
      int gap;
      csr_valid <= 1'b0;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= t_raw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic [62:0] pack3(int x, int y, int z);
      logic [62:0] v;
      v[CW-1:0] = CW'(x);
      v[2*CW-1:CW] = CW'(y);
      v[3*CW-1:2*CW] = CW'(z);
      return v;
   endfunction

   function automatic logic [62:0] small_vec();
      return pack3($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                   $urandom_range(0, 4096) - 2048);
   endfunction

   function automatic logic [62:0] rand_vec();
      return 63'({$urandom, $urandom});
   endfunction

   // Unit reference and normal, each a random axis permutation with sign.
   task automatic set_unit_frame();
      int ref_axis, nrm_axis;
      int rv[3], nv[3];
      ref_axis = $urandom_range(0, 2);
      nrm_axis = (ref_axis + $urandom_range(1, 2)) % 3;
      rv = '{0, 0, 0};
      nv = '{0, 0, 0};
      rv[ref_axis] = $urandom_range(0, 1) ? 1024 : -1024;
      nv[nrm_axis] = $urandom_range(0, 1) ? 1024 : -1024;
      write_reg(ccpe_pkg::REG_AXIS, pack3(rv[0], rv[1], rv[2]));
      write_reg(ccpe_pkg::REG_NORMAL, pack3(nv[0], nv[1], nv[2]));
   endtask

   logic [PW-1:0] edge_t[$] = '{24'h000000, 24'h7fffff, 24'h800000, 24'hffffff,
      24'h000001, 24'h100000, 24'hf00000, 24'h3243f7, 24'hcdbc09, 24'h1921fb,
      24'he6de05, 24'h6487ed, 24'h9b7813};

   initial begin
      int phase;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset configuration, then each kind at extreme settings.
      foreach (edge_t[i]) send_param(edge_t[i], 0);
      drain();
      write_reg(ccpe_pkg::REG_KIND, 63'(ccpe_pkg::KIND_LINE));
      write_reg(ccpe_pkg::REG_ORIGIN, pack3(1048575, -1048576, 0));
      write_reg(ccpe_pkg::REG_AXIS, pack3(-1048576, 1048575, 1024));
      for (int i = 0; i < 4; i++) send_param(edge_t[i], 0);
      drain();
      write_reg(ccpe_pkg::REG_KIND, 63'(ccpe_pkg::KIND_CIRCLE));
      write_reg(ccpe_pkg::REG_ORIGIN, '0);
      set_unit_frame();
      write_reg(ccpe_pkg::REG_RADIUS, 63'(20'hfffff));
      for (int i = 4; i < 13; i++) send_param(edge_t[i], 0);
      drain();
      write_reg(ccpe_pkg::REG_KIND, 63'(ccpe_pkg::KIND_ELLIPSE));
      write_reg(ccpe_pkg::REG_SEMI_A, 63'(20'hfffff));
      write_reg(ccpe_pkg::REG_SEMI_B, '0);
      write_reg(ccpe_pkg::REG_ORIGIN, pack3(1048575, 1048575, -1048576));
      send_param(24'h000000, 0);
      send_param(24'h7fffff, 0);
      drain();
      // Unused kind passes the origin through.
      write_reg(ccpe_pkg::REG_KIND, 63'(KIND_NONE));
      send_param(24'h123456, 0);
      drain();

      // Random phases, mostly sane unit frames, some unnormalized noise.
      for (phase = 0; phase < 24; phase++) begin
         write_reg(ccpe_pkg::REG_KIND,
                   63'((phase % 8 == 7) ? KIND_NONE : 2'($urandom_range(0, 2))));
         write_reg(ccpe_pkg::REG_ORIGIN,
                   ($urandom_range(0, 3) == 0) ? rand_vec() : small_vec());
         if ($urandom_range(0, 3) == 0) begin
            write_reg(ccpe_pkg::REG_AXIS, rand_vec());
            write_reg(ccpe_pkg::REG_NORMAL, rand_vec());
         end else if (kind_reg == ccpe_pkg::KIND_LINE) begin
            write_reg(ccpe_pkg::REG_AXIS, small_vec());
         end else begin
            set_unit_frame();
         end
         write_reg(ccpe_pkg::REG_RADIUS,
                   63'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8192)));
         write_reg(ccpe_pkg::REG_SEMI_A,
                   63'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8192)));
         write_reg(ccpe_pkg::REG_SEMI_B,
                   63'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8192)));
         if (phase == 5) hold_off = 1;
         // The hold-off phase offers more words than the pipeline holds.
         for (int i = 0; i < ((phase == 5) ? 50 : 25); i++)
            send_param(24'($urandom), phase == 5);
         drain();
      end

      $display("covered line, circle, ellipse and unused kinds over %0d points, %0d saturated",
               results_seen, sat_seen);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
